[src/vdss_pkg.sv]
`timescale 1ns / 1ps
// Package for the VBUS debounce and sample scheduler.
// Holds the request payload type, debounce status type and CSR index constants.
// Depends on nothing.
package vdss_pkg;

   // Register indexes on the CSR write channel.
   localparam logic [7:0] CSR_DEBOUNCE_COUNT      = 8'd0;
   localparam logic [7:0] CSR_DETAIL_INTERVAL     = 8'd1;
   localparam logic [7:0] CSR_BACKGROUND_INTERVAL = 8'd2;

   localparam logic [7:0]  DEBOUNCE_COUNT_RESET      = 8'd3;
   localparam logic [31:0] DETAIL_INTERVAL_RESET     = 32'd1000;
   localparam logic [31:0] BACKGROUND_INTERVAL_RESET = 32'd60000;

   // Saturation value of the candidate counter.
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        vbus_read_ok;
      logic        vbus_present;
      logic        charge_read_ok;
      logic        charge_raw;
      logic        telemetry_ok;
      logic        detail_active;
      logic        notified;
      logic        detail_on_wake;
      logic [31:0] wake_ms;
   } req_type;

   typedef struct packed {
      logic changed;
      logic stable;
      logic charging;
      logic charging_ok;
   } deb_status_type;

endpackage

[src/vbus_debounce_sample_scheduler_core.sv]
`timescale 1ns / 1ps
// Top level of the VBUS debounce and sample scheduler.
// Depends on vdss_pkg, vdss_debounce and vdss_sched.
//
// Usage:
//   Each request on the req_ channel is one poll tick: the tick time, the
//   VBUS, charging and telemetry read results, detail mode and the wake
//   notification that follows the tick. Each request yields exactly one
//   response on the rsp_ channel carrying the publish, due and change flags,
//   the debounced VBUS level, the charging flags and the snapshot stamp.
//   The csr_ channel writes the debounce count and the two sample intervals;
//   it is always ready and should only be written while no request is in
//   flight.
// Flow:
//   A request is captured in an input register, evaluated by short logic
//   against the debounce and scheduler state, and lands in the response
//   register when that is free. One request per cycle is sustained while
//   rsp_ready stays high; a tick's state update happens as it moves into
//   the response register, so the next tick sees it at once.
// Reset and stalls:
//   Synchronous reset empties both stages and restores the register and
//   state defaults. If the receiver holds rsp_ready low, the response is
//   held, one more request may sit in the input register, and req_ready
//   drops until the response is taken.
module vbus_debounce_sample_scheduler_core #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        req_vbus_read_ok,
   input  logic        req_vbus_present,
   input  logic        req_charge_read_ok,
   input  logic        req_charge_raw,
   input  logic        req_telemetry_ok,
   input  logic        req_detail_active,
   input  logic        req_notified,
   input  logic        req_detail_on_wake,
   input  logic [31:0] req_wake_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_publish,
   output logic        rsp_sample_due,
   output logic        rsp_vbus_changed,
   output logic        rsp_vbus_stable,
   output logic        rsp_charging,
   output logic        rsp_charging_valid,
   output logic [31:0] rsp_stamp_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration registers.
   logic [7:0]  debounce_count_ff;
   logic [31:0] detail_interval_ff;
   logic [31:0] background_interval_ff;

   // Input stage.
   logic              s1_valid_ff;
   vdss_pkg::req_type s1_req_ff;
   vdss_pkg::req_type req_in;

   // Response stage.
   logic        rsp_valid_ff;
   logic        rsp_publish_ff;
   logic        rsp_due_ff;
   logic        rsp_changed_ff;
   logic        rsp_stable_ff;
   logic        rsp_chg_ff;
   logic        rsp_chg_ok_ff;
   logic [31:0] rsp_stamp_ff;

   logic                     out_free;
   logic                     advance;
   logic                     req_fire;
   vdss_pkg::deb_status_type deb;
   logic                     publish;
   logic                     due_now;
   logic [31:0]              stamp_ms;

   // The CSR channel never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_count_ff      <= vdss_pkg::DEBOUNCE_COUNT_RESET;
         detail_interval_ff     <= vdss_pkg::DETAIL_INTERVAL_RESET;
         background_interval_ff <= vdss_pkg::BACKGROUND_INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vdss_pkg::CSR_DEBOUNCE_COUNT: begin
               debounce_count_ff <= csr_wdata[7:0];
            end
            vdss_pkg::CSR_DETAIL_INTERVAL: begin
               detail_interval_ff <= csr_wdata;
            end
            vdss_pkg::CSR_BACKGROUND_INTERVAL: begin
               background_interval_ff <= csr_wdata;
            end
            default: begin
               // Writes to unknown indexes are dropped.
            end
         endcase
      end
   end

   // The response register can take a new tick when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign req_in.now_ms         = req_now_ms;
   assign req_in.vbus_read_ok   = req_vbus_read_ok;
   assign req_in.vbus_present   = req_vbus_present;
   assign req_in.charge_read_ok = req_charge_read_ok;
   assign req_in.charge_raw     = req_charge_raw;
   assign req_in.telemetry_ok   = req_telemetry_ok;
   assign req_in.detail_active  = req_detail_active;
   assign req_in.notified       = req_notified;
   assign req_in.detail_on_wake = req_detail_on_wake;
   assign req_in.wake_ms        = req_wake_ms;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_in;
      end
   end

   vdss_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .update         (advance),
      .vbus_read_ok   (s1_req_ff.vbus_read_ok),
      .vbus_present   (s1_req_ff.vbus_present),
      .charge_read_ok (s1_req_ff.charge_read_ok),
      .charge_raw     (s1_req_ff.charge_raw),
      .debounce_count (debounce_count_ff),
      .status         (deb)
   );

   vdss_sched #(
      .TIME_BITS (TIME_BITS)
   ) u_sched (
      .clock               (clock),
      .reset               (reset),
      .update              (advance),
      .req                 (s1_req_ff),
      .deb                 (deb),
      .detail_interval     (detail_interval_ff),
      .background_interval (background_interval_ff),
      .publish             (publish),
      .due_now             (due_now),
      .stamp_ms            (stamp_ms)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_publish_ff <= publish;
         rsp_due_ff     <= due_now;
         rsp_changed_ff <= deb.changed;
         rsp_stable_ff  <= deb.stable;
         rsp_chg_ff     <= deb.charging;
         rsp_chg_ok_ff  <= deb.charging_ok;
         rsp_stamp_ff   <= stamp_ms;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_publish        = rsp_publish_ff;
   assign rsp_sample_due     = rsp_due_ff;
   assign rsp_vbus_changed   = rsp_changed_ff;
   assign rsp_vbus_stable    = rsp_stable_ff;
   assign rsp_charging       = rsp_chg_ff;
   assign rsp_charging_valid = rsp_chg_ok_ff;
   assign rsp_stamp_ms       = rsp_stamp_ff;

`ifndef SYNTH
   // A published snapshot is always a due sample or a VBUS change.
   a_publish_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_publish_ff) |-> (rsp_due_ff || rsp_changed_ff))
      else $error("publish without due sample or change");

   // The stamp is zero whenever nothing is published.
   a_stamp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_publish_ff) |-> (rsp_stamp_ff == 32'd0))
      else $error("stamp set without publish");

   // No response comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

[src/vdss_debounce.sv]
`timescale 1ns / 1ps
// VBUS presence debouncer with a saturating candidate counter and charging flags.
// Depends on vdss_pkg.
module vdss_debounce (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  logic                     vbus_read_ok,
   input  logic                     vbus_present,
   input  logic                     charge_read_ok,
   input  logic                     charge_raw,
   input  logic [7:0]               debounce_count,
   output vdss_pkg::deb_status_type status
);

   logic       ready_ff, ready_in;
   logic       stable_ff, stable_in;
   logic       cand_ff, cand_in;
   logic [7:0] count_ff, count_in;
   logic       chg_ff, chg_in;
   logic       chg_ok_ff, chg_ok_in;
   logic [7:0] count_inc;
   logic       changed;

   always_comb begin
      ready_in  = ready_ff;
      stable_in = stable_ff;
      cand_in   = cand_ff;
      count_in  = count_ff;
      chg_in    = chg_ff;
      chg_ok_in = chg_ok_ff;
      changed   = 1'b0;
      count_inc = (count_ff < vdss_pkg::COUNT_MAX) ? count_ff + 8'd1 : count_ff;
      if (vbus_read_ok) begin
         if (!ready_ff) begin
            // First good read sets the baseline.
            ready_in  = 1'b1;
            stable_in = vbus_present;
            cand_in   = vbus_present;
            count_in  = 8'd0;
            chg_in    = 1'b0;
            chg_ok_in = !vbus_present;
         end else if (vbus_present == stable_ff) begin
            cand_in  = vbus_present;
            count_in = 8'd0;
         end else if (vbus_present != cand_ff) begin
            cand_in  = vbus_present;
            count_in = 8'd1;
         end else begin
            count_in = count_inc;
            if (count_inc >= debounce_count) begin
               stable_in = vbus_present;
               count_in  = 8'd0;
               changed   = 1'b1;
               if (!vbus_present) begin
                  chg_in    = 1'b0;
                  chg_ok_in = 1'b1;
               end else begin
                  chg_ok_in = charge_read_ok;
                  chg_in    = charge_read_ok && charge_raw;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         stable_ff <= 1'b0;
         cand_ff   <= 1'b0;
         count_ff  <= 8'd0;
         chg_ff    <= 1'b0;
         chg_ok_ff <= 1'b0;
      end else if (update) begin
         ready_ff  <= ready_in;
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         count_ff  <= count_in;
         chg_ff    <= chg_in;
         chg_ok_ff <= chg_ok_in;
      end
   end

   assign status.changed     = changed;
   assign status.stable      = stable_in;
   assign status.charging    = chg_in;
   assign status.charging_ok = chg_ok_in;

`ifndef SYNTH
   // The stable level only moves once a baseline exists.
   a_stable_needs_baseline: assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> !stable_ff)
      else $error("stable level set before baseline");

   // A reported change always flips the stable level.
   a_change_flips: assert property (@(posedge clock) disable iff (reset)
      (update && changed) |=> (stable_ff != $past(stable_ff)))
      else $error("change reported without level flip");

   // The counter is cleared whenever the candidate matches the stable level.
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (ready_ff && cand_ff == stable_ff) |-> (count_ff == 8'd0))
      else $error("candidate count not cleared");
`endif

endmodule

[src/vdss_sched.sv]
`timescale 1ns / 1ps
// Telemetry sample scheduler: due decision, publish decision and sample timing state.
// Depends on vdss_pkg.
module vdss_sched #(
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     update,
   input  vdss_pkg::req_type        req,
   input  vdss_pkg::deb_status_type deb,
   input  logic [31:0]              detail_interval,
   input  logic [31:0]              background_interval,
   output logic                     publish,
   output logic                     due_now,
   output logic [31:0]              stamp_ms
);

   localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic                 sampled_ff, sampled_in;
   logic                 force_ff, force_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [CMP_BITS-1:0]  now_wide, wake_wide;
   logic [TIME_BITS-1:0] now_t, wake_t, elapsed;
   logic [31:0]          interval;
   logic [CMP_BITS-1:0]  stamp_wide;

   assign now_wide   = CMP_BITS'(req.now_ms);
   assign wake_wide  = CMP_BITS'(req.wake_ms);
   assign now_t      = now_wide[TIME_BITS-1:0];
   assign wake_t     = wake_wide[TIME_BITS-1:0];
   assign elapsed    = now_t - last_ff;
   assign interval   = req.detail_active ? detail_interval : background_interval;
   assign due_now    = force_ff || !sampled_ff ||
                       (CMP_BITS'(elapsed) >= CMP_BITS'(interval));
   assign publish    = req.vbus_read_ok && (!due_now || req.telemetry_ok) &&
                       (due_now || deb.changed);
   assign stamp_wide = CMP_BITS'(now_t);
   assign stamp_ms   = publish ? stamp_wide[31:0] : 32'd0;

   always_comb begin
      sampled_in = sampled_ff;
      last_in    = last_ff;
      force_in   = 1'b0;
      if (publish && due_now) begin
         sampled_in = 1'b1;
         last_in    = now_t;
      end
      if (req.notified) begin
         if (req.detail_on_wake) begin
            force_in = 1'b1;
         end else if (sampled_in) begin
            last_in = wake_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff <= 1'b0;
         force_ff   <= 1'b1;
         last_ff    <= '0;
      end else if (update) begin
         sampled_ff <= sampled_in;
         force_ff   <= force_in;
         last_ff    <= last_in;
      end
   end

`ifndef SYNTH
   // Before the first sample every tick is due.
   a_due_before_first: assert property (@(posedge clock) disable iff (reset)
      !sampled_ff |-> due_now)
      else $error("sample not due before first sample");

   // A published due sample marks the scheduler as sampled.
   a_sampled_sets: assert property (@(posedge clock) disable iff (reset)
      (update && publish && due_now) |=> sampled_ff)
      else $error("sampled flag not set after sample");

   // A wake with detail subscribers forces the next tick due.
   a_wake_forces: assert property (@(posedge clock) disable iff (reset)
      (update && req.notified && req.detail_on_wake) |=> force_ff)
      else $error("wake did not force next sample");
`endif

endmodule

[tb/tb_vbus_debounce_sample_scheduler_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for vbus_debounce_sample_scheduler_core.
// Depends on vdss_pkg and the core. A predictor or the table checks each response.
module tb_vbus_debounce_sample_scheduler_core;

   // Period is 8 ns. The watchdog counts cycles in which no channel moves anything.
   localparam int unsigned HANG_LIMIT    = 5000;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned RANDOM_PHASES = 5;

   // One response as the core should report it.
   typedef struct packed {
      logic        publish;
      logic        due;
      logic        changed;
      logic        vbus_stable;
      logic        charging;
      logic        charging_ok;
      logic [31:0] stamp_ms;
   } tick_result_type;

   // One row of the directed table: a tick request or a register write.
   typedef enum bit {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [7:0]        index;
      logic [31:0]       wdata;
      vdss_pkg::req_type tick;
      bit                typed;
      tick_result_type   want;
   } dir_row_type;

   // Register values for one random phase, and the number of ticks it runs.
   typedef struct {
      logic [7:0]  debounce;
      logic [31:0] detail_span;
      logic [31:0] background_span;
      int unsigned ticks;
   } phase_cfg_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_now_ms;
   logic        req_vbus_read_ok;
   logic        req_vbus_present;
   logic        req_charge_read_ok;
   logic        req_charge_raw;
   logic        req_telemetry_ok;
   logic        req_detail_active;
   logic        req_notified;
   logic        req_detail_on_wake;
   logic [31:0] req_wake_ms;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_publish;
   logic        rsp_sample_due;
   logic        rsp_vbus_changed;
   logic        rsp_vbus_stable;
   logic        rsp_charging;
   logic        rsp_charging_valid;
   logic [31:0] rsp_stamp_ms;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;

   // Shadow copy of the configuration registers.
   logic [7:0]  cfg_debounce;
   logic [31:0] cfg_detail_ms;
   logic [31:0] cfg_background_ms;

   // Shadow copy of the debounce and scheduler state.
   logic        sh_armed;
   logic        sh_level;
   logic        sh_cand_level;
   logic [7:0]  sh_cand_cnt;
   logic        sh_chg;
   logic        sh_chg_ok;
   logic        sh_sampled;
   logic        sh_force;
   logic [31:0] sh_last_ms;

   // State of the random tick generator: a wall clock, the VBUS level being
   // held and how many more good reads it is held for, and the detail mode.
   logic [31:0] gen_time;
   logic        gen_level;
   int unsigned gen_run;
   logic        gen_detail;

   tick_result_type pending_results[$];
   dir_row_type     dir_rows[$];

   int unsigned stall_pct = 23;
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned n_ticks = 0;
   int unsigned n_directed = 0;
   int unsigned n_results = 0;
   int unsigned n_published = 0;
   int unsigned n_changes = 0;
   int unsigned n_due = 0;

   vbus_debounce_sample_scheduler_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .req_vbus_read_ok   (req_vbus_read_ok),
      .req_vbus_present   (req_vbus_present),
      .req_charge_read_ok (req_charge_read_ok),
      .req_charge_raw     (req_charge_raw),
      .req_telemetry_ok   (req_telemetry_ok),
      .req_detail_active  (req_detail_active),
      .req_notified       (req_notified),
      .req_detail_on_wake (req_detail_on_wake),
      .req_wake_ms        (req_wake_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_publish        (rsp_publish),
      .rsp_sample_due     (rsp_sample_due),
      .rsp_vbus_changed   (rsp_vbus_changed),
      .rsp_vbus_stable    (rsp_vbus_stable),
      .rsp_charging       (rsp_charging),
      .rsp_charging_valid (rsp_charging_valid),
      .rsp_stamp_ms       (rsp_stamp_ms),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // Works out the response to one tick and advances the shadow state, in
   // the same order as the core: schedule check on the old state, then the
   // debounce update, then the publish decision, then the wake handling.
   function automatic tick_result_type predict_tick(input vdss_pkg::req_type r);
      tick_result_type o;
      logic [31:0]     span;
      logic [31:0]     elapsed;
      logic            due;
      logic            changed;
      logic            pub;
      span    = r.detail_active ? cfg_detail_ms : cfg_background_ms;
      elapsed = r.now_ms - sh_last_ms;
      due     = sh_force || !sh_sampled || (elapsed >= span);
      changed = 1'b0;
      if (r.vbus_read_ok) begin
         if (!sh_armed) begin
            // The first good read becomes the baseline without a change.
            sh_armed      = 1'b1;
            sh_level      = r.vbus_present;
            sh_cand_level = r.vbus_present;
            sh_cand_cnt   = 8'd0;
            sh_chg        = 1'b0;
            sh_chg_ok     = !r.vbus_present;
         end else if (r.vbus_present == sh_level) begin
            sh_cand_level = r.vbus_present;
            sh_cand_cnt   = 8'd0;
         end else if (r.vbus_present != sh_cand_level) begin
            sh_cand_level = r.vbus_present;
            sh_cand_cnt   = 8'd1;
         end else begin
            if (sh_cand_cnt != vdss_pkg::COUNT_MAX) sh_cand_cnt = sh_cand_cnt + 8'd1;
            if (sh_cand_cnt >= cfg_debounce) begin
               sh_level    = r.vbus_present;
               sh_cand_cnt = 8'd0;
               changed     = 1'b1;
               if (!r.vbus_present) begin
                  sh_chg    = 1'b0;
                  sh_chg_ok = 1'b1;
               end else begin
                  sh_chg_ok = r.charge_read_ok;
                  sh_chg    = r.charge_read_ok && r.charge_raw;
               end
            end
         end
      end
      pub = r.vbus_read_ok && (!due || r.telemetry_ok) && (due || changed);
      if (pub && due) begin
         sh_sampled = 1'b1;
         sh_last_ms = r.now_ms;
      end
      sh_force = 1'b0;
      if (r.notified) begin
         if (r.detail_on_wake) sh_force = 1'b1;
         else if (sh_sampled) sh_last_ms = r.wake_ms;
      end
      o.publish     = pub;
      o.due         = due;
      o.changed     = changed;
      o.vbus_stable = sh_level;
      o.charging    = sh_chg;
      o.charging_ok = sh_chg_ok;
      o.stamp_ms    = pub ? r.now_ms : 32'd0;
      return o;
   endfunction

   function automatic vdss_pkg::req_type mk_req(input logic [31:0] now, input logic vok,
                                                input logic pres, input logic cok,
                                                input logic craw, input logic tok,
                                                input logic det, input logic ntf,
                                                input logic dwk, input logic [31:0] wake);
      vdss_pkg::req_type r;
      r.now_ms         = now;
      r.vbus_read_ok   = vok;
      r.vbus_present   = pres;
      r.charge_read_ok = cok;
      r.charge_raw     = craw;
      r.telemetry_ok   = tok;
      r.detail_active  = det;
      r.notified       = ntf;
      r.detail_on_wake = dwk;
      r.wake_ms        = wake;
      return r;
   endfunction

   function automatic tick_result_type mk_res(input logic pub, input logic due, input logic chg,
                                              input logic stb, input logic c, input logic cv,
                                              input logic [31:0] stamp);
      tick_result_type o;
      o = '{pub, due, chg, stb, c, cv, stamp};
      return o;
   endfunction

   function automatic void add_tick(input vdss_pkg::req_type r, input bit typed,
                                    input tick_result_type want);
      dir_row_type row;
      row.kind  = ROW_TICK;
      row.index = '0;
      row.wdata = '0;
      row.tick  = r;
      row.typed = typed;
      row.want  = want;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [7:0] index, input logic [31:0] wdata);
      dir_row_type row;
      row.kind  = ROW_CSR;
      row.index = index;
      row.wdata = wdata;
      row.tick  = '0;
      row.typed = 1'b0;
      row.want  = '0;
      dir_rows.push_back(row);
   endfunction

   // Builds the next random tick. Most ticks follow a plausible poll sequence:
   // time moves forward, often by about one sample interval, and VBUS is held
   // at one level for a run that is either a short glitch or just long enough
   // to pass the debounce count. The rest are fully random noise.
   task automatic next_tick(output vdss_pkg::req_type r);
      logic [31:0] span;
      logic [31:0] step;
      int unsigned pick;
      if ($urandom_range(99) < 12) begin
         r = mk_req($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    $urandom());
      end else begin
         if ($urandom_range(99) < 5) gen_detail = ~gen_detail;
         span = gen_detail ? cfg_detail_ms : cfg_background_ms;
         pick = $urandom_range(99);
         if (pick < 45) step = $urandom_range(40);
         else if (pick < 80) step = span - 32'd2 + $urandom_range(4);
         else if (pick < 95) step = $urandom_range(span);
         else step = $urandom();
         gen_time = gen_time + step;
         if (gen_run == 0) begin
            gen_level = 1'($urandom_range(1));
            if ($urandom_range(1)) gen_run = $urandom_range(1, 3);
            else gen_run = cfg_debounce + $urandom_range(3);
         end
         r = mk_req(gen_time, $urandom_range(99) >= 8, gen_level, $urandom_range(99) >= 15,
                    1'($urandom_range(1)), $urandom_range(99) >= 10, gen_detail,
                    $urandom_range(99) < 10, 1'($urandom_range(1)),
                    gen_time + $urandom_range(20));
         if (r.vbus_read_ok && gen_run != 0) gen_run = gen_run - 1;
      end
   endtask

   // Offers one tick request, idling at random first. Valid is only lowered
   // in a step where it is not also raised. On acceptance the expected
   // response is queued: the typed one where the table gives it, else the
   // predicted one. The predictor runs either way to keep its state in step.
   task automatic send_tick(input vdss_pkg::req_type r, input bit typed,
                            input tick_result_type want);
      tick_result_type guess;
      while ($urandom_range(99) < stall_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_ms         <= r.now_ms;
      req_vbus_read_ok   <= r.vbus_read_ok;
      req_vbus_present   <= r.vbus_present;
      req_charge_read_ok <= r.charge_read_ok;
      req_charge_raw     <= r.charge_raw;
      req_telemetry_ok   <= r.telemetry_ok;
      req_detail_active  <= r.detail_active;
      req_notified       <= r.notified;
      req_detail_on_wake <= r.detail_on_wake;
      req_wake_ms        <= r.wake_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_tick(r);
      pending_results.push_back(typed ? want : guess);
      n_ticks++;
   endtask

   // Writes one register once the core has drained. Every request yields a
   // response, so an empty queue means it is idle.
   task automatic csr_write(input logic [7:0] index, input logic [31:0] wdata);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         vdss_pkg::CSR_DEBOUNCE_COUNT:      cfg_debounce      = wdata[7:0];
         vdss_pkg::CSR_DETAIL_INTERVAL:     cfg_detail_ms     = wdata;
         vdss_pkg::CSR_BACKGROUND_INTERVAL: cfg_background_ms = wdata;
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Response side: random back-pressure, and every accepted response is
   // compared with the oldest expectation.
   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("rsp_publish", 32'(want.publish), 32'(rsp_publish));
               check_field("rsp_sample_due", 32'(want.due), 32'(rsp_sample_due));
               check_field("rsp_vbus_changed", 32'(want.changed), 32'(rsp_vbus_changed));
               check_field("rsp_vbus_stable", 32'(want.vbus_stable), 32'(rsp_vbus_stable));
               check_field("rsp_charging", 32'(want.charging), 32'(rsp_charging));
               check_field("rsp_charging_valid", 32'(want.charging_ok),
                           32'(rsp_charging_valid));
               check_field("rsp_stamp_ms", want.stamp_ms, rsp_stamp_ms);
               n_published += 32'(rsp_publish);
               n_changes   += 32'(rsp_vbus_changed);
               n_due       += 32'(rsp_sample_due);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: ends the run if no channel makes progress for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= HANG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      phase_cfg_type     phases [RANDOM_PHASES];
      vdss_pkg::req_type r;
      int unsigned       k;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_now_ms         = '0;
      req_vbus_read_ok   = 1'b0;
      req_vbus_present   = 1'b0;
      req_charge_read_ok = 1'b0;
      req_charge_raw     = 1'b0;
      req_telemetry_ok   = 1'b0;
      req_detail_active  = 1'b0;
      req_notified       = 1'b0;
      req_detail_on_wake = 1'b0;
      req_wake_ms        = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      cfg_debounce       = vdss_pkg::DEBOUNCE_COUNT_RESET;
      cfg_detail_ms      = vdss_pkg::DETAIL_INTERVAL_RESET;
      cfg_background_ms  = vdss_pkg::BACKGROUND_INTERVAL_RESET;
      sh_armed           = 1'b0;
      sh_level           = 1'b0;
      sh_cand_level      = 1'b0;
      sh_cand_cnt        = 8'd0;
      sh_chg             = 1'b0;
      sh_chg_ok          = 1'b0;
      sh_sampled         = 1'b0;
      sh_force           = 1'b1;
      sh_last_ms         = 32'd0;
      gen_time           = 32'd0;
      gen_level          = 1'b0;
      gen_run            = 0;
      gen_detail         = 1'b0;

      // Directed table, run at the reset register values at first.
      // A failed VBUS read right after reset: due is forced, nothing is
      // published and the level still reads low before the baseline.
      add_tick(mk_req(32'd0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0), 1, mk_res(0, 1, 0, 0, 0, 0, 32'd0));
      // Baseline read with VBUS present while telemetry fails: the level is
      // taken, charging is cleared and marked not valid, no publish.
      add_tick(mk_req(32'd5, 1, 1, 0, 0, 0, 0, 0, 0, 32'd0), 1, mk_res(0, 1, 0, 1, 0, 0, 32'd0));
      // First successful sample is published with its stamp.
      add_tick(mk_req(32'd10, 1, 1, 0, 0, 1, 0, 0, 0, 32'd0), 1, mk_res(1, 1, 0, 1, 0, 0, 32'd10));
      // Well inside the background interval: nothing due, nothing published.
      add_tick(mk_req(32'd20, 1, 1, 0, 0, 1, 0, 0, 0, 32'd0), 1, mk_res(0, 0, 0, 1, 0, 0, 32'd0));
      // Three differing reads in a row pass the default debounce count of
      // three; a change to absent publishes with charging valid.
      add_tick(mk_req(32'd30, 1, 0, 0, 0, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd40, 1, 0, 0, 0, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd50, 1, 0, 1, 1, 1, 0, 0, 0, 32'd0), 1, mk_res(1, 0, 1, 0, 0, 1, 32'd50));
      // A glitch back to the stable level restarts the candidate count.
      add_tick(mk_req(32'd60, 1, 1, 1, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd70, 1, 0, 1, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd80, 1, 1, 0, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      // A failed read in the middle leaves the count where it was.
      add_tick(mk_req(32'd90, 0, 0, 0, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd100, 1, 1, 0, 1, 0, 0, 0, 0, 32'd0), 0, '0);
      // Change to present with a failed charging read.
      add_tick(mk_req(32'd110, 1, 1, 0, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      // Background interval elapsed, then the detail interval.
      add_tick(mk_req(32'd60010, 1, 1, 1, 1, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd61010, 1, 1, 1, 1, 1, 1, 0, 0, 32'd0), 0, '0);
      // Wake with detail subscribers forces the next sample; that sample
      // fails telemetry, and a plain wake then moves the sample time to the
      // top of the time range so the next check wraps around zero.
      add_tick(mk_req(32'd61020, 1, 1, 1, 1, 1, 1, 1, 1, 32'd0), 0, '0);
      add_tick(mk_req(32'd61021, 1, 1, 1, 1, 0, 1, 1, 0, 32'hFFFF_FFFF), 0, '0);
      add_tick(mk_req(32'd998, 1, 1, 1, 1, 1, 1, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd999, 1, 1, 1, 1, 1, 1, 0, 0, 32'd0), 0, '0);
      // Debounce count below two still needs a second differing read.
      add_csr(vdss_pkg::CSR_DEBOUNCE_COUNT, 32'hA5A5_A501);
      add_tick(mk_req(32'd1000, 1, 0, 1, 1, 1, 1, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd1001, 1, 0, 1, 1, 1, 1, 0, 0, 32'd0), 0, '0);
      add_csr(vdss_pkg::CSR_DEBOUNCE_COUNT, 32'h5A5A_5A00);
      add_csr(vdss_pkg::CSR_DETAIL_INTERVAL, 32'd1);
      add_csr(vdss_pkg::CSR_BACKGROUND_INTERVAL, 32'hFFFF_FFFF);
      // Telemetry fails on a tick that is both due and a VBUS change: the
      // change is kept but nothing is published.
      add_tick(mk_req(32'd2000, 1, 1, 1, 1, 0, 1, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd2001, 1, 1, 1, 1, 0, 1, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'd2002, 1, 1, 1, 0, 1, 0, 0, 0, 32'd0), 0, '0);
      add_tick(mk_req(32'hFFFF_FFFF, 1, 1, 1, 0, 1, 0, 1, 0, 32'hFFFF_FFFF), 0, '0);

      // Random phases, covering the smallest and largest debounce counts and
      // intervals. The slow debounce phase gets the most ticks.
      phases[0] = '{8'd2, 32'd1000, 32'd60000, 300};
      phases[1] = '{8'd255, 32'd1, 32'hFFFF_FFFF, 450};
      phases[2] = '{8'd0, 32'hFFFF_FFFF, 32'd1, 250};
      phases[3] = '{8'd4, 32'd20, 32'd300, 300};
      phases[4] = '{8'd1, 32'd500, 32'd5000, 300};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            csr_write(dir_rows[i].index, dir_rows[i].wdata);
         end else begin
            send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
            n_directed++;
         end
      end

      k = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         csr_write(vdss_pkg::CSR_DEBOUNCE_COUNT,
                   {24'($urandom_range(32'hFF_FFFF)), phases[p].debounce});
         csr_write(vdss_pkg::CSR_DETAIL_INTERVAL, phases[p].detail_span);
         csr_write(vdss_pkg::CSR_BACKGROUND_INTERVAL, phases[p].background_span);
         gen_run = 0;
         repeat (phases[p].ticks) begin
            // A long stretch in the middle runs at full rate on both sides.
            stall_pct = (k >= 700 && k < 1000) ? 0 : 23;
            next_tick(r);
            send_tick(r, 1'b0, '0);
            k++;
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ticks (%0d directed) over %0d register settings; %0d responses checked.",
               n_ticks, n_directed, RANDOM_PHASES + 3, n_results);
      $display("Responses held %0d due samples, %0d published snapshots, %0d VBUS changes.",
               n_due, n_published, n_changes);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
src/vdss_pkg.sv
src/vdss_debounce.sv
src/vdss_sched.sv
src/vbus_debounce_sample_scheduler_core.sv
tb/tb_vbus_debounce_sample_scheduler_core.sv
